>>> src/ect_pkg.sv
`default_nettype none

package ect_pkg;

   localparam int NUM_COUNTERS = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int THREAD_BITS  = 8;

   localparam int IDX_W   = $clog2(NUM_COUNTERS);
   localparam int ABORT_W = $clog2(NUM_COUNTERS + 1);

   localparam int FUNC_W     = 3;
   localparam int ID_W       = 4;
   localparam int TID_IN_W   = 8;
   localparam int STATUS_W   = 2;
   localparam int ASSIGNED_W = 4;
   localparam int WAKE_W     = 8;
   localparam int ABORTED_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_CREATE     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DESTROY    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_WAIT       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WAIT_CLEAR = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SIGNAL     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ABORT      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic capture;
      logic scan_step;
      logic exec;
      logic rsp_load;
   } ect_cmd_type;

   typedef struct packed {
      logic is_scan;
      logic is_create;
      logic hit_free;
      logic idx_last;
   } ect_stat_type;

endpackage

`default_nettype wire

>>> src/ect_ctrl.sv
`default_nettype none

module ect_ctrl
   import ect_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   input  wire ect_stat_type stat,
   output ect_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (stat.is_scan) begin
               cmd.scan_step = 1'b1;
               if ((stat.is_create && stat.hit_free) || stat.idx_last) begin
                  state_in = ST_RESP;
               end
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/ect_dp.sv
`default_nettype none

module ect_dp
   import ect_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [ID_W-1:0]       req_counter_id,
   input  wire logic [TID_IN_W-1:0]   req_thread_id,
   input  wire ect_cmd_type           cmd,
   output ect_stat_type               stat,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ASSIGNED_W-1:0]      rsp_assigned_id,
   output logic                       rsp_caller_blocks,
   output logic                       rsp_wake_valid,
   output logic [WAKE_W-1:0]          rsp_wake_thread,
   output logic [ABORTED_W-1:0]       rsp_aborted_count
);

   logic                   in_use_ff [NUM_COUNTERS];
   logic                   wp_ff     [NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0] cnt_ff    [NUM_COUNTERS];
   logic [THREAD_BITS-1:0] wt_ff     [NUM_COUNTERS];

   logic [FUNC_W-1:0]      func_ff;
   logic                   id_ok_ff;
   logic [THREAD_BITS-1:0] tid_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [ASSIGNED_W-1:0]  assigned_ff, assigned_in;
   logic                   blocks_ff, blocks_in;
   logic                   wake_v_ff, wake_v_in;
   logic [WAKE_W-1:0]      wake_t_ff, wake_t_in;
   logic [ABORT_W-1:0]     abort_ff, abort_in;

   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [ASSIGNED_W-1:0]  rsp_assigned_ff;
   logic                   rsp_blocks_ff;
   logic                   rsp_wake_v_ff;
   logic [WAKE_W-1:0]      rsp_wake_t_ff;
   logic [ABORTED_W-1:0]   rsp_aborted_ff;

   logic                   use_we, use_in, wp_we, wp_in, cnt_we, wt_we;
   logic [COUNT_WIDTH-1:0] cnt_in, cnt_up, cnt_dn;

   logic                   cur_use, cur_wp;
   logic [COUNT_WIDTH-1:0] cur_cnt;
   logic [THREAD_BITS-1:0] cur_wt;
   logic                   req_is_scan;

   assign cur_use = in_use_ff[idx_ff];
   assign cur_wp  = wp_ff[idx_ff];
   assign cur_cnt = cnt_ff[idx_ff];
   assign cur_wt  = wt_ff[idx_ff];

   assign cnt_up = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
   assign cnt_dn = (cur_cnt == CNT_MIN) ? cur_cnt : cur_cnt - COUNT_WIDTH'(1);

   assign req_is_scan = (req_func == FUNC_CREATE) || (req_func == FUNC_ABORT);

   assign stat.is_scan   = (func_ff == FUNC_CREATE) || (func_ff == FUNC_ABORT);
   assign stat.is_create = (func_ff == FUNC_CREATE);
   assign stat.hit_free  = !cur_use;
   assign stat.idx_last  = (idx_ff == IDX_W'(NUM_COUNTERS - 1));

   always_comb begin
      use_we      = 1'b0;
      use_in      = 1'b0;
      wp_we       = 1'b0;
      wp_in       = 1'b0;
      cnt_we      = 1'b0;
      cnt_in      = cur_cnt;
      wt_we       = 1'b0;
      idx_in      = idx_ff;
      status_in   = status_ff;
      assigned_in = assigned_ff;
      blocks_in   = blocks_ff;
      wake_v_in   = wake_v_ff;
      wake_t_in   = wake_t_ff;
      abort_in    = abort_ff;

      if (cmd.capture) begin
         idx_in      = req_is_scan ? '0 : IDX_W'(req_counter_id);
         status_in   = (req_func == FUNC_CREATE) ? ST_FULL : ST_OK;
         assigned_in = '0;
         blocks_in   = 1'b0;
         wake_v_in   = 1'b0;
         wake_t_in   = '0;
         abort_in    = '0;
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (func_ff == FUNC_CREATE) begin
            if (!cur_use) begin
               use_we      = 1'b1;
               use_in      = 1'b1;
               wp_we       = 1'b1;
               wp_in       = 1'b0;
               cnt_we      = 1'b1;
               cnt_in      = '0;
               status_in   = ST_OK;
               assigned_in = ASSIGNED_W'(idx_ff);
            end
         end else if (cur_use && cur_wp && (cur_wt == tid_ff)) begin
            wp_we    = 1'b1;
            wp_in    = 1'b0;
            cnt_we   = 1'b1;
            cnt_in   = cnt_up;
            abort_in = abort_ff + ABORT_W'(1);
         end
      end else if (cmd.exec) begin
         if (!(id_ok_ff && cur_use)) begin
            status_in = ST_INVALID;
         end else begin
            case (func_ff)
               FUNC_DESTROY, FUNC_SIGNAL: begin
                  cnt_we = 1'b1;
                  cnt_in = cnt_up;
                  if (cur_wp) begin
                     wp_we     = 1'b1;
                     wp_in     = 1'b0;
                     wake_v_in = 1'b1;
                     wake_t_in = WAKE_W'(cur_wt);
                  end
                  if (func_ff == FUNC_DESTROY) begin
                     use_we = 1'b1;
                     use_in = 1'b0;
                  end
               end
               FUNC_WAIT: begin
                  if (!cur_cnt[COUNT_WIDTH-1] && (cur_cnt != '0)) begin
                     cnt_we = 1'b1;
                     cnt_in = cur_cnt - COUNT_WIDTH'(1);
                  end else if (!cur_wp) begin
                     cnt_we    = 1'b1;
                     cnt_in    = cnt_dn;
                     wp_we     = 1'b1;
                     wp_in     = 1'b1;
                     wt_we     = 1'b1;
                     blocks_in = 1'b1;
                  end else begin
                     status_in = ST_NO_SPACE;
                  end
               end
               FUNC_WAIT_CLEAR: begin
                  if (!cur_wp) begin
                     cnt_we    = 1'b1;
                     cnt_in    = '1;
                     wp_we     = 1'b1;
                     wp_in     = 1'b1;
                     wt_we     = 1'b1;
                     blocks_in = 1'b1;
                  end else begin
                     status_in = ST_NO_SPACE;
                  end
               end
               default: begin
                  status_in = ST_INVALID;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            in_use_ff[i] <= 1'b0;
            wp_ff[i]     <= 1'b0;
         end
      end else begin
         if (use_we) begin
            in_use_ff[idx_ff] <= use_in;
         end
         if (wp_we) begin
            wp_ff[idx_ff] <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[idx_ff] <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_ff[idx_ff] <= tid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         id_ok_ff <= (32'(req_counter_id) < 32'(NUM_COUNTERS));
         tid_ff   <= THREAD_BITS'(req_thread_id);
      end
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      assigned_ff <= assigned_in;
      blocks_ff   <= blocks_in;
      wake_v_ff   <= wake_v_in;
      wake_t_ff   <= wake_t_in;
      abort_ff    <= abort_in;
      if (cmd.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_assigned_ff <= assigned_ff;
         rsp_blocks_ff   <= blocks_ff;
         rsp_wake_v_ff   <= wake_v_ff;
         rsp_wake_t_ff   <= wake_t_ff;
         rsp_aborted_ff  <= ABORTED_W'(abort_ff);
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_id   = rsp_assigned_ff;
   assign rsp_caller_blocks = rsp_blocks_ff;
   assign rsp_wake_valid    = rsp_wake_v_ff;
   assign rsp_wake_thread   = rsp_wake_t_ff;
   assign rsp_aborted_count = rsp_aborted_ff;

endmodule

`default_nettype wire

>>> src/event_counter_table.sv
// Table of event counters, each a counting semaphore with at most one waiter.
// One request item (req_func, req_counter_id, req_thread_id) is taken on the
// req_valid/req_ready handshake and gives exactly one response item on the
// rsp_valid/rsp_ready handshake.
// The block works on one item at a time. Destroy, wait, wait_clear, signal
// and unused codes are handled in the execute state without a slot walk;
// the result then goes to the response register and the block returns to
// idle, ready for the next item.
// Create walks the slots from the lowest, one per cycle, and stops at the
// first free slot, or after the last slot when the table is full.
// Abort always walks every slot; both walks use the single state read port.
// The response sits in an output register, so a new request is accepted
// while an earlier response still waits; when the receiver stalls, the
// finished item waits in its final stage and holds off further requests.
// Reset is synchronous and clears all slots, counts and waiters at once.
`default_nettype none

module event_counter_table
   import ect_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [ID_W-1:0]       req_counter_id,
   input  wire logic [TID_IN_W-1:0]   req_thread_id,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ASSIGNED_W-1:0]      rsp_assigned_id,
   output logic                       rsp_caller_blocks,
   output logic                       rsp_wake_valid,
   output logic [WAKE_W-1:0]          rsp_wake_thread,
   output logic [ABORTED_W-1:0]       rsp_aborted_count
);

   ect_cmd_type  cmd;
   ect_stat_type stat;

   ect_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ect_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_counter_id    (req_counter_id),
      .req_thread_id     (req_thread_id),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_thread   (rsp_wake_thread),
      .rsp_aborted_count (rsp_aborted_count)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in progress");

   a_fail_no_side_info: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |->
         (rsp_assigned_id == '0 && !rsp_caller_blocks && !rsp_wake_valid))
      else $error("failed item reports a side effect");

   a_abort_only_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_aborted_count != '0)) |->
         (!rsp_wake_valid && !rsp_caller_blocks && rsp_status == ST_OK))
      else $error("abort item mixed with other results");

   a_block_no_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_caller_blocks) |-> !rsp_wake_valid)
      else $error("item both blocks the caller and wakes a thread");
`endif

endmodule

`default_nettype wire

>>> tb/sv/ect_reply_checker.sv
`default_nettype none

module ect_reply_checker
   import ect_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [ID_W-1:0]       req_counter_id,
   input  wire logic [TID_IN_W-1:0]   req_thread_id,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [STATUS_W-1:0]   rsp_status,
   input  wire logic [ASSIGNED_W-1:0] rsp_assigned_id,
   input  wire logic                  rsp_caller_blocks,
   input  wire logic                  rsp_wake_valid,
   input  wire logic [WAKE_W-1:0]     rsp_wake_thread,
   input  wire logic [ABORTED_W-1:0]  rsp_aborted_count,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ASSIGNED_W-1:0] assigned_id;
      logic                  caller_blocks;
      logic                  wake_valid;
      logic [WAKE_W-1:0]     wake_thread;
      logic [ABORTED_W-1:0]  aborted_count;
   } table_reply_type;

   logic                          slot_used  [NUM_COUNTERS];
   logic signed [COUNT_WIDTH-1:0] slot_count [NUM_COUNTERS];
   logic                          has_waiter [NUM_COUNTERS];
   logic [THREAD_BITS-1:0]        waiter_tid [NUM_COUNTERS];
   table_reply_type               reply_backlog [$];

   function automatic void bump_count(int s);
      if (slot_count[s] != CNT_MAX) begin
         slot_count[s] = COUNT_WIDTH'(slot_count[s] + 1);
      end
   endfunction

   function automatic void drop_count(int s);
      if (slot_count[s] != CNT_MIN) begin
         slot_count[s] = COUNT_WIDTH'(slot_count[s] - 1);
      end
   endfunction

   function automatic void release_waiter(int s, inout table_reply_type r);
      bump_count(s);
      if (has_waiter[s]) begin
         has_waiter[s] = 1'b0;
         r.wake_valid  = 1'b1;
         r.wake_thread = WAKE_W'(waiter_tid[s]);
      end
   endfunction

   function automatic table_reply_type apply_table_op(logic [FUNC_W-1:0] func,
                                                      logic [ID_W-1:0] id,
                                                      logic [TID_IN_W-1:0] thread);
      table_reply_type r;
      logic [THREAD_BITS-1:0] tid;
      logic live;
      int s;
      int i;
      r = '0;
      tid = thread[THREAD_BITS-1:0];
      s = int'(id);
      live = (s < NUM_COUNTERS) && slot_used[s];
      case (func)
         FUNC_CREATE: begin
            r.status = ST_FULL;
            for (i = 0; i < NUM_COUNTERS && r.status == ST_FULL; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i]  = 1'b1;
                  slot_count[i] = '0;
                  has_waiter[i] = 1'b0;
                  r.status      = ST_OK;
                  r.assigned_id = ASSIGNED_W'(i);
               end
            end
         end
         FUNC_ABORT: begin
            for (i = 0; i < NUM_COUNTERS; i++) begin
               if (slot_used[i] && has_waiter[i] && waiter_tid[i] == tid) begin
                  has_waiter[i] = 1'b0;
                  bump_count(i);
                  r.aborted_count = r.aborted_count + 1'b1;
               end
            end
         end
         FUNC_DESTROY: begin
            if (!live) begin
               r.status = ST_INVALID;
            end else begin
               release_waiter(s, r);
               slot_used[s] = 1'b0;
            end
         end
         FUNC_WAIT: begin
            if (!live) begin
               r.status = ST_INVALID;
            end else if (slot_count[s] > 0) begin
               slot_count[s] = COUNT_WIDTH'(slot_count[s] - 1);
            end else if (!has_waiter[s]) begin
               drop_count(s);
               has_waiter[s]   = 1'b1;
               waiter_tid[s]   = tid;
               r.caller_blocks = 1'b1;
            end else begin
               r.status = ST_NO_SPACE;
            end
         end
         FUNC_WAIT_CLEAR: begin
            if (!live) begin
               r.status = ST_INVALID;
            end else if (!has_waiter[s]) begin
               slot_count[s]   = '1;
               has_waiter[s]   = 1'b1;
               waiter_tid[s]   = tid;
               r.caller_blocks = 1'b1;
            end else begin
               r.status = ST_NO_SPACE;
            end
         end
         FUNC_SIGNAL: begin
            if (!live) begin
               r.status = ST_INVALID;
            end else begin
               release_waiter(s, r);
            end
         end
         default: begin
            r.status = ST_INVALID;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field_name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      table_reply_type want;
      int k;
      if (reset) begin
         for (k = 0; k < NUM_COUNTERS; k++) begin
            slot_used[k]  = 1'b0;
            slot_count[k] = '0;
            has_waiter[k] = 1'b0;
            waiter_tid[k] = '0;
         end
         reply_backlog.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_backlog.size() == 0) begin
               $error("reply item with none outstanding: status %0d", rsp_status);
               fail_count++;
            end else begin
               want = reply_backlog.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("assigned_id", 32'(want.assigned_id), 32'(rsp_assigned_id));
               check_field("caller_blocks", 32'(want.caller_blocks),
                           32'(rsp_caller_blocks));
               check_field("wake_valid", 32'(want.wake_valid), 32'(rsp_wake_valid));
               check_field("wake_thread", 32'(want.wake_thread), 32'(rsp_wake_thread));
               check_field("aborted_count", 32'(want.aborted_count),
                           32'(rsp_aborted_count));
            end
         end
         if (req_valid && req_ready) begin
            reply_backlog.push_back(apply_table_op(req_func, req_counter_id, req_thread_id));
         end
      end
      pending_count <= reply_backlog.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_event_counter_table.sv
`default_nettype none

module tb_event_counter_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ect_pkg::*;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int RANDOM_ITEMS     = 590;
   localparam int FAST_SIGNALS     = 8;
   localparam int DRAIN_CYCLES     = 2 * NUM_COUNTERS + 8;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [FUNC_W-1:0]     req_func       = '0;
   logic [ID_W-1:0]       req_counter_id = '0;
   logic [TID_IN_W-1:0]   req_thread_id  = '0;
   logic                  rsp_ready      = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ASSIGNED_W-1:0] rsp_assigned_id;
   logic                  rsp_caller_blocks;
   logic                  rsp_wake_valid;
   logic [WAKE_W-1:0]     rsp_wake_thread;
   logic [ABORTED_W-1:0]  rsp_aborted_count;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int burst_left  = 0;
   bit gaps_on     = 1'b1;
   bit stalls_on   = 1'b1;

   event_counter_table i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_counter_id    (req_counter_id),
      .req_thread_id     (req_thread_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_thread   (rsp_wake_thread),
      .rsp_aborted_count (rsp_aborted_count)
   );

   ect_reply_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_counter_id    (req_counter_id),
      .req_thread_id     (req_thread_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_caller_blocks (rsp_caller_blocks),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_thread   (rsp_wake_thread),
      .rsp_aborted_count (rsp_aborted_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int n;
      forever begin
         if (!stalls_on) begin
            @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
               @(negedge clock);
               rsp_ready = 1'b1;
            end
            n = $urandom_range(0, 6);
            repeat (n) begin
               @(negedge clock);
               rsp_ready = 1'b0;
            end
         end
      end
   end

   task automatic issue_request(input logic [FUNC_W-1:0] func,
                                input logic [ID_W-1:0] id,
                                input logic [TID_IN_W-1:0] tid);
      int gap;
      if (gaps_on && burst_left == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      req_valid      = 1'b1;
      req_func       = func;
      req_counter_id = id;
      req_thread_id  = tid;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   function automatic logic [TID_IN_W-1:0] pick_thread();
      if ($urandom_range(0, 9) < 7) begin
         return TID_IN_W'($urandom_range(0, 5));
      end
      return TID_IN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 13) return FUNC_CREATE;
      if (r < 25) return FUNC_DESTROY;
      if (r < 45) return FUNC_WAIT;
      if (r < 55) return FUNC_WAIT_CLEAR;
      if (r < 78) return FUNC_SIGNAL;
      if (r < 94) return FUNC_ABORT;
      if (r < 97) return FUNC_SPARE_A;
      return FUNC_SPARE_B;
   endfunction

   initial begin
      int k;
      int i;
      logic [ID_W-1:0] slot;
      logic [TID_IN_W-1:0] tid;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue_request(FUNC_SIGNAL, 4'd15, 8'h00);
      issue_request(FUNC_CREATE, 4'd0, 8'h00);
      issue_request(FUNC_CREATE, 4'd0, 8'h00);
      issue_request(FUNC_CREATE, 4'd0, 8'h00);
      issue_request(FUNC_WAIT, 4'd0, 8'hFF);
      issue_request(FUNC_WAIT, 4'd0, 8'h01);
      issue_request(FUNC_WAIT_CLEAR, 4'd0, 8'h02);
      issue_request(FUNC_SIGNAL, 4'd0, 8'h00);
      issue_request(FUNC_SIGNAL, 4'd0, 8'h00);
      issue_request(FUNC_WAIT, 4'd0, 8'h03);
      issue_request(FUNC_WAIT_CLEAR, 4'd1, 8'hAA);
      issue_request(FUNC_WAIT, 4'd2, 8'hAA);
      issue_request(FUNC_ABORT, 4'd0, 8'hAA);
      issue_request(FUNC_ABORT, 4'd0, 8'h55);
      issue_request(FUNC_WAIT, 4'd2, 8'h00);
      issue_request(FUNC_DESTROY, 4'd2, 8'h00);
      issue_request(FUNC_WAIT, 4'd2, 8'h10);
      issue_request(FUNC_DESTROY, 4'd15, 8'hFF);
      issue_request(FUNC_SPARE_A, 4'd0, 8'h00);
      issue_request(FUNC_SPARE_B, 4'd15, 8'hFF);
      issue_request(FUNC_CREATE, 4'd0, 8'h00);

      // Fill the table, overflow it, then park one thread on every slot and abort it.
      for (i = 0; i < NUM_COUNTERS - 2; i++) begin
         issue_request(FUNC_CREATE, 4'd0, 8'h00);
      end
      for (i = 0; i < NUM_COUNTERS; i++) begin
         issue_request(FUNC_WAIT_CLEAR, ID_W'(i), 8'h77);
      end
      issue_request(FUNC_ABORT, 4'd0, 8'h77);

      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      for (i = 0; i < FAST_SIGNALS; i++) begin
         issue_request(FUNC_SIGNAL, 4'd5, 8'h00);
      end
      issue_request(FUNC_WAIT, 4'd5, 8'h09);
      issue_request(FUNC_SIGNAL, 4'd5, 8'h00);
      issue_request(FUNC_SIGNAL, 4'd5, 8'h00);
      issue_request(FUNC_WAIT, 4'd5, 8'h09);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;

      k = 0;
      while (k < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) == 0) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 2) == 0) begin
            slot = ID_W'($urandom_range(0, NUM_COUNTERS - 1));
            tid  = pick_thread();
            issue_request($urandom_range(0, 1) ? FUNC_WAIT : FUNC_WAIT_CLEAR, slot, tid);
            case ($urandom_range(0, 2))
               0: issue_request(FUNC_ABORT, ID_W'($urandom), tid);
               1: issue_request(FUNC_DESTROY, slot, pick_thread());
               default: issue_request(FUNC_SIGNAL, slot, pick_thread());
            endcase
            k += 2;
         end else begin
            issue_request(pick_func(), ID_W'($urandom_range(0, NUM_COUNTERS - 1)),
                          pick_thread());
            k++;
         end
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
src/ect_pkg.sv
src/ect_ctrl.sv
src/ect_dp.sv
src/event_counter_table.sv
tb/sv/ect_reply_checker.sv
tb/sv/tb_event_counter_table.sv
